// ----- rtl/rlkd_pkg.sv -----
// ----------------------------------------------------------------------------
// Resistor-ladder key debouncer package
// Band and key codes, ladder constants and the pad-to-key mapping.
// ----------------------------------------------------------------------------
package rlkd_pkg;

   localparam int ADC_W  = 12;
   localparam int BAND_W = 4;
   localparam int KEY_W  = 3;
   localparam int RUN_W  = 8;

   typedef logic [BAND_W-1:0] band_type;
   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [RUN_W-1:0]  run_type;

   localparam int LADDER_FULL  = 4095;
   localparam int LADDER_SCALE = 32;
   localparam int LADDER_TOP_K = 29;
   localparam int NUM_PADS     = 9;

   // Ladder multipliers for pads 8 down to 0.
   localparam int PAD_K [NUM_PADS] = '{25, 23, 21, 19, 17, 15, 13, 11, 9};

   localparam band_type BAND_NONE = band_type'(10);
   localparam band_type BAND_UP   = band_type'(0);
   localparam band_type BAND_MODE = band_type'(4);
   localparam band_type BAND_ONOF = band_type'(5);
   localparam band_type BAND_DOWN = band_type'(6);

   localparam key_type KEY_NONE   = key_type'(0);
   localparam key_type KEY_UP     = key_type'(1);
   localparam key_type KEY_DOWN   = key_type'(2);
   localparam key_type KEY_MODE   = key_type'(3);
   localparam key_type KEY_ON_OFF = key_type'(4);

   localparam run_type RUN_MAX = run_type'(255);

   // Smallest average whose scaled value reaches k full-scale steps.
   function automatic int ladder_min_avg(int k);
      return (k * LADDER_FULL + LADDER_SCALE - 1) / LADDER_SCALE;
   endfunction

   function automatic key_type band_to_key(band_type band);
      key_type key;
      unique case (band)
         BAND_UP:   key = KEY_UP;
         BAND_DOWN: key = KEY_DOWN;
         BAND_MODE: key = KEY_MODE;
         BAND_ONOF: key = KEY_ON_OFF;
         default:   key = KEY_NONE;
      endcase
      return key;
   endfunction

endpackage

// ----- rtl/resistor_ladder_key_debouncer_top.sv -----
// ----------------------------------------------------------------------------
// Resistor-ladder key debouncer
// Averages groups of ADC samples, classifies the ladder pad and debounces it.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid, req_stall, req_adc_sample    | in
//  rsp     | rsp_valid, rsp_stall, rsp_key_code,     | out
//          | rsp_stable_band                         |
//  csr     | csr_wr_en, csr_wr_data                  | in
//
// One sample is taken per cycle unless req_stall holds the last sample of a
// group. That sample enters the group register, and from there its classified
// and debounced result moves into the output register once that is free.
// Synchronous reset clears the sum, sample count, debounce state and the
// pipeline valids, and loads the threshold with 4.
// A stalled result blocks only the last sample of the next group once the
// group register is also full; other samples keep flowing.
// ----------------------------------------------------------------------------
module resistor_ladder_key_debouncer_top
   import rlkd_pkg::*;
#(
   parameter int SAMPLES_PER_TICK = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [ADC_W-1:0]  req_adc_sample,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [KEY_W-1:0]  rsp_key_code,
   output logic [BAND_W-1:0] rsp_stable_band,
   input  logic              csr_wr_en,
   input  logic [RUN_W-1:0]  csr_wr_data
);

   localparam int SUM_W = $clog2(LADDER_FULL * SAMPLES_PER_TICK + 1);
   localparam int IDX_W = (SAMPLES_PER_TICK > 1) ? $clog2(SAMPLES_PER_TICK) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES_PER_TICK - 1);

   // A group sum reaches pad k when it is at least N times the smallest
   // average that reaches it; this avoids forming the average at all.
   function automatic logic [SUM_W-1:0] sum_limit(int k);
      return SUM_W'(SAMPLES_PER_TICK * ladder_min_avg(k));
   endfunction

   logic [RUN_W-1:0] threshold_ff, threshold_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [IDX_W-1:0] index_ff, index_in;
   logic             tick_valid_ff, tick_valid_in;
   logic [SUM_W-1:0] tick_sum_ff, tick_sum_in;
   band_type         candidate_ff, candidate_in;
   run_type          run_ff, run_in;
   band_type         settled_ff, settled_in;
   logic             rsp_valid_ff, rsp_valid_in;
   key_type          key_ff, key_in;
   band_type         band_ff, band_in;

   logic             req_take;
   logic             is_last;
   logic             out_free;
   logic             tick_free;
   logic             tick_move;
   logic [SUM_W-1:0] group_sum;
   band_type         now_band;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign tick_move = tick_valid_ff && out_free;
   assign tick_free = !tick_valid_ff || out_free;
   assign is_last   = (index_ff == IDX_LAST);
   assign req_stall = is_last && !tick_free;
   assign req_take  = req_valid && !req_stall;
   assign group_sum = sum_ff + SUM_W'(req_adc_sample);

   // Accumulation side.
   always_comb begin
      threshold_in  = csr_wr_en ? csr_wr_data : threshold_ff;
      sum_in        = sum_ff;
      index_in      = index_ff;
      tick_valid_in = tick_valid_ff && !tick_move;
      tick_sum_in   = tick_sum_ff;
      if (req_take) begin
         if (is_last) begin
            sum_in        = '0;
            index_in      = '0;
            tick_valid_in = 1'b1;
            tick_sum_in   = group_sum;
         end else begin
            sum_in   = group_sum;
            index_in = index_ff + IDX_W'(1);
         end
      end
   end

   // Pad classification of the registered group sum.
   always_comb begin
      now_band = BAND_NONE;
      for (int i = NUM_PADS - 1; i >= 0; i--) begin
         if (tick_sum_ff >= sum_limit(PAD_K[i])) begin
            now_band = band_type'(NUM_PADS - 1 - i);
         end
      end
      if (tick_sum_ff >= sum_limit(LADDER_TOP_K)) begin
         now_band = BAND_NONE;
      end
   end

   // Debounce and result register.
   always_comb begin
      candidate_in = candidate_ff;
      run_in       = run_ff;
      settled_in   = settled_ff;
      rsp_valid_in = rsp_valid_ff && !(rsp_valid_ff && !rsp_stall);
      key_in       = key_ff;
      band_in      = band_ff;
      if (tick_move) begin
         if (now_band == candidate_ff) begin
            if (run_ff != RUN_MAX) begin
               run_in = run_ff + run_type'(1);
            end
         end else begin
            candidate_in = now_band;
            run_in       = run_type'(1);
         end
         if (run_in >= threshold_ff) begin
            settled_in = candidate_in;
         end
         rsp_valid_in = 1'b1;
         key_in       = band_to_key(settled_in);
         band_in      = settled_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= RUN_W'(4);
         sum_ff        <= '0;
         index_ff      <= '0;
         tick_valid_ff <= 1'b0;
         candidate_ff  <= BAND_NONE;
         run_ff        <= '0;
         settled_ff    <= BAND_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         threshold_ff  <= threshold_in;
         sum_ff        <= sum_in;
         index_ff      <= index_in;
         tick_valid_ff <= tick_valid_in;
         candidate_ff  <= candidate_in;
         run_ff        <= run_in;
         settled_ff    <= settled_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tick_sum_ff <= tick_sum_in;
      key_ff      <= key_in;
      band_ff     <= band_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_key_code    = key_ff;
   assign rsp_stable_band = band_ff;

`ifndef SYNTH
   // The sample counter never passes the end of a group.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      index_ff <= IDX_LAST)
      else $error("sample index beyond group length");

   // A group sum that cannot move on must stay put.
   a_tick_hold: assert property (@(posedge clock) disable iff (reset)
      tick_valid_ff && !out_free |=> tick_valid_ff && $stable(tick_sum_ff))
      else $error("pending group sum lost or changed");

   // A result always carries a legal pad and the key that belongs to it.
   a_rsp_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_stable_band <= band_type'(8) || rsp_stable_band == BAND_NONE)
                    && rsp_key_code == band_to_key(rsp_stable_band))
      else $error("result pad and key disagree");

   // The run counter is nonzero once any group has been classified.
   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> run_ff != '0)
      else $error("run counter zero after a classification");
`endif

endmodule
